// ===== src/fpv3_pkg.sv =====
package fpv3_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // divider: |a| << FRAC_BITS over |b|, one quotient bit per cycle
    localparam int DIV_W     = WORD_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // square root: operand below 2^(31+FRAC_BITS), width rounded down to even
    localparam int SQ_W      = ((WORD_W + FRAC_BITS) / 2) * 2;
    localparam int SQ_STEPS  = SQ_W / 2;
    localparam int SQ_CNT_W  = $clog2(SQ_STEPS);
    localparam int ROOT_W    = SQ_W / 2;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_MUL   = 4'd2;
    localparam logic [3:0] CMD_DIV   = 4'd3;
    localparam logic [3:0] CMD_MIN   = 4'd4;
    localparam logic [3:0] CMD_MAX   = 4'd5;
    localparam logic [3:0] CMD_DOT   = 4'd6;
    localparam logic [3:0] CMD_CROSS = 4'd7;
    localparam logic [3:0] CMD_MAGSQ = 4'd8;
    localparam logic [3:0] CMD_NORM  = 4'd9;
    localparam logic [3:0] CMD_SQRT  = 4'd10;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MIN,
        OP_MAX,
        OP_DOT,
        OP_CROSS,
        OP_MAGSQ,
        OP_NORM,
        OP_SQRT,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] a_x;
        logic signed [WORD_W-1:0] a_y;
        logic signed [WORD_W-1:0] a_z;
        logic signed [WORD_W-1:0] b_x;
        logic signed [WORD_W-1:0] b_y;
        logic signed [WORD_W-1:0] b_z;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // product >> FRAC_BITS (floor), saturated to +/- SAT_MAX
    function automatic logic signed [WORD_W-1:0] fx_sat(input logic signed [2*WORD_W-1:0] p);
        logic signed [2*WORD_W-1:0] q;
        logic signed [WORD_W-1:0]   r;
        q = p >>> FRAC_BITS;
        if (q > 64'(SAT_MAX))
            r = SAT_MAX;
        else if (q < -64'(SAT_MAX))
            r = -SAT_MAX;
        else
            r = q[WORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== src/fpv3_req_if.sv =====
interface fpv3_req_if;
    logic                       valid;
    logic                       ready;
    logic [3:0]                 command;
    logic signed [31:0]         a_x;
    logic signed [31:0]         a_y;
    logic signed [31:0]         a_z;
    logic signed [31:0]         b_x;
    logic signed [31:0]         b_y;
    logic signed [31:0]         b_z;

    modport source (output valid, command, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, command, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

// ===== src/fpv3_rsp_if.sv =====
interface fpv3_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic               zero_divisor;

    modport source (output valid, res_x, res_y, res_z, zero_divisor, input ready);
    modport sink   (input valid, res_x, res_y, res_z, zero_divisor, output ready);
endinterface

// ===== src/fixed_point_vec3_alu.sv =====
// Signed Q24.8 three-lane vector ALU. Request words carry a command and two vectors and are
// taken into a four-entry queue whenever it has room, so the requester is not held up while
// earlier words are executing or a result waits on the response side; one response word
// comes back per request, in order. Execution is one word at a time behind the queue:
// add, sub, min and max finish in the start state and unused codes give zero; mul, dot,
// magsq and cross use the multipliers, sqrt the 20-step root unit, div the 40-step
// restoring dividers (one per lane) and normalize the products, root, then the three dividers.
module fixed_point_vec3_alu (
    input  logic       clk,
    input  logic       rst_n,
    fpv3_req_if.sink   req,
    fpv3_rsp_if.source rsp
);
    import fpv3_pkg::*;

    queue_head_t head;
    logic        pop;

    fpv3_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    fpv3_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

// ===== src/fpv3_front.sv =====
module fpv3_front (
    input  logic                clk,
    input  logic                rst_n,
    fpv3_req_if.sink            req,
    output fpv3_pkg::queue_head_t head,
    input  logic                pop
);
    import fpv3_pkg::*;

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push;
    logic                do_pop;
    op_t                 op;

    always_comb
    begin
        unique case (req.command)
            CMD_ADD:   op = OP_ADD;
            CMD_SUB:   op = OP_SUB;
            CMD_MUL:   op = OP_MUL;
            CMD_DIV:   op = OP_DIV;
            CMD_MIN:   op = OP_MIN;
            CMD_MAX:   op = OP_MAX;
            CMD_DOT:   op = OP_DOT;
            CMD_CROSS: op = OP_CROSS;
            CMD_MAGSQ: op = OP_MAGSQ;
            CMD_NORM:  op = OP_NORM;
            CMD_SQRT:  op = OP_SQRT;
            default:   op = OP_NONE;
        endcase
    end

    assign req.ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push       = req.valid && req.ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= '{op: op, a_x: req.a_x, a_y: req.a_y, a_z: req.a_z,
                                     b_x: req.b_x, b_y: req.b_y, b_z: req.b_z};
    end

endmodule

// ===== src/fpv3_sqrt.sv =====
module fpv3_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [fpv3_pkg::WORD_W-1:0] operand,
    output logic                             done,
    output logic [fpv3_pkg::ROOT_W-1:0]      root
);
    import fpv3_pkg::*;

    logic [SQ_W-1:0]     n_reg, n_next;
    logic [SQ_W-1:0]     root_reg, root_next;
    logic [SQ_W-1:0]     bit_reg, bit_next;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [SQ_W-1:0]     trial;

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        n_next    = n_reg;
        root_next = root_reg >> 1;
        bit_next  = bit_reg >> 2;
        if (n_reg >= trial)
        begin
            n_next    = n_reg - trial;
            root_next = (root_reg >> 1) + bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CNT_W'(SQ_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= (operand > 0) ? (SQ_W'(unsigned'(operand)) << FRAC_BITS) : '0;
            root_reg <= '0;
            bit_reg  <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (busy_reg)
        begin
            n_reg    <= n_next;
            root_reg <= root_next;
            bit_reg  <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule

// ===== src/fpv3_div.sv =====
module fpv3_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [fpv3_pkg::WORD_W-1:0] dividend,
    input  logic signed [fpv3_pkg::WORD_W-1:0] divisor,
    output logic                               done,
    output logic signed [fpv3_pkg::WORD_W-1:0] quotient,
    output logic                               zero
);
    import fpv3_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    d_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [WORD_W:0]      rem_sh;
    logic                 q_bit;
    logic [WORD_W-1:0]    a_mag;
    logic [WORD_W-1:0]    b_mag;
    logic [WORD_W-1:0]    clamp;

    assign a_mag  = dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
    assign b_mag  = divisor[WORD_W-1]  ? WORD_W'(-divisor)  : WORD_W'(divisor);
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {a_mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            d_reg   <= b_mag;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? WORD_W'(rem_sh - {1'b0, d_reg}) : rem_sh[WORD_W-1:0];
        end
    end

    assign clamp    = (quo_reg > DIV_W'(SAT_MAX)) ? WORD_W'(SAT_MAX) : quo_reg[WORD_W-1:0];
    assign zero     = (d_reg == '0);
    assign quotient = zero ? SAT_MAX : (neg_reg ? signed'(WORD_W'(-clamp)) : signed'(clamp));
    assign done     = done_reg;

endmodule

// ===== src/fpv3_back.sv =====
module fpv3_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fpv3_pkg::queue_head_t head,
    output logic                  pop,
    fpv3_rsp_if.source            rsp
);
    import fpv3_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CROSS,
        ST_COMB,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    item_t                      item_reg;
    logic signed [2*WORD_W-1:0] prod_reg [3];
    logic signed [WORD_W-1:0]   tmp_reg  [3];
    logic signed [WORD_W-1:0]   res_reg  [3];
    logic                       zdiv_reg;
    logic                       out_valid_reg;
    logic signed [WORD_W-1:0]   out_x_reg, out_y_reg, out_z_reg;
    logic                       out_z_flag_reg;

    logic signed [WORD_W-1:0]   mul_a [3];
    logic signed [WORD_W-1:0]   mul_b [3];
    logic signed [WORD_W-1:0]   sp    [3];
    logic signed [WORD_W-1:0]   sum;
    logic signed [WORD_W-1:0]   av    [3];
    logic signed [WORD_W-1:0]   bv    [3];

    logic                       sqrt_start;
    logic signed [WORD_W-1:0]   sqrt_operand;
    logic                       sqrt_done;
    logic [ROOT_W-1:0]          root;
    logic                       div_start;
    logic signed [WORD_W-1:0]   div_divisor [3];
    logic [2:0]                 div_done;
    logic signed [WORD_W-1:0]   quo [3];
    logic [2:0]                 div_zero;
    logic                       out_free;

    assign av[0] = item_reg.a_x;
    assign av[1] = item_reg.a_y;
    assign av[2] = item_reg.a_z;
    assign bv[0] = item_reg.b_x;
    assign bv[1] = item_reg.b_y;
    assign bv[2] = item_reg.b_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul_a[i] = av[i];
            mul_b[i] = bv[i];
        end
        if (state_reg == ST_CROSS)
        begin
            mul_a[0] = av[2]; mul_b[0] = bv[1];
            mul_a[1] = av[0]; mul_b[1] = bv[2];
            mul_a[2] = av[1]; mul_b[2] = bv[0];
        end
        else if (item_reg.op == OP_CROSS)
        begin
            mul_a[0] = av[1]; mul_b[0] = bv[2];
            mul_a[1] = av[2]; mul_b[1] = bv[0];
            mul_a[2] = av[0]; mul_b[2] = bv[1];
        end
        else if (item_reg.op == OP_MAGSQ || item_reg.op == OP_NORM)
        begin
            for (int i = 0; i < 3; i++)
                mul_b[i] = av[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sp[i] = fx_sat(prod_reg[i]);
        sum = sp[0] + sp[1] + sp[2];
    end

    assign sqrt_start   = (state_reg == ST_START && item_reg.op == OP_SQRT) ||
                          (state_reg == ST_COMB  && item_reg.op == OP_NORM);
    assign sqrt_operand = (state_reg == ST_START) ? item_reg.a_x : sum;
    assign div_start    = (state_reg == ST_START && item_reg.op == OP_DIV) ||
                          (state_reg == ST_SQRT && sqrt_done && item_reg.op == OP_NORM &&
                           root != '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            div_divisor[i] = (item_reg.op == OP_DIV) ? bv[i] : signed'(WORD_W'(root));
    end

    fpv3_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_operand),
        .done    (sqrt_done),
        .root    (root)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        fpv3_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (av[g]),
            .divisor  (div_divisor[g]),
            .done     (div_done[g]),
            .quotient (quo[g]),
            .zero     (div_zero[g])
        );
    end

    assign out_free = !out_valid_reg || rsp.ready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= mul_a[i] * mul_b[i];
        if (pop)
            item_reg <= head.item;
        if (state_reg == ST_CROSS)
            for (int i = 0; i < 3; i++)
                tmp_reg[i] <= sp[i];
        case (state_reg)
            ST_START:
            begin
                zdiv_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    case (item_reg.op)
                        OP_ADD:  res_reg[i] <= av[i] + bv[i];
                        OP_SUB:  res_reg[i] <= av[i] - bv[i];
                        OP_MIN:  res_reg[i] <= (av[i] < bv[i]) ? av[i] : bv[i];
                        OP_MAX:  res_reg[i] <= (av[i] > bv[i]) ? av[i] : bv[i];
                        default: res_reg[i] <= '0;
                    endcase
                end
            end
            ST_COMB:
            begin
                case (item_reg.op) inside
                    OP_MUL:
                        for (int i = 0; i < 3; i++)
                            res_reg[i] <= sp[i];
                    OP_CROSS:
                        for (int i = 0; i < 3; i++)
                            res_reg[i] <= tmp_reg[i] - sp[i];
                    OP_DOT, OP_MAGSQ:
                        res_reg[0] <= sum;
                    default:
                    begin
                    end
                endcase
            end
            ST_SQRT:
                if (sqrt_done && item_reg.op == OP_SQRT)
                    res_reg[0] <= signed'(WORD_W'(root));
            ST_DIV:
                if (div_done[0])
                begin
                    for (int i = 0; i < 3; i++)
                        res_reg[i] <= quo[i];
                    zdiv_reg <= (item_reg.op == OP_DIV) && (|div_zero);
                end
            default:
            begin
            end
        endcase
        if (state_reg == ST_OUT && out_free)
        begin
            out_x_reg      <= res_reg[0];
            out_y_reg      <= res_reg[1];
            out_z_reg      <= res_reg[2];
            out_z_flag_reg <= zdiv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (head.valid)
                        state_reg <= ST_START;
                ST_START:
                begin
                    case (item_reg.op) inside
                        OP_MUL, OP_DOT, OP_MAGSQ, OP_NORM: state_reg <= ST_COMB;
                        OP_CROSS:                          state_reg <= ST_CROSS;
                        OP_DIV:                            state_reg <= ST_DIV;
                        OP_SQRT:                           state_reg <= ST_SQRT;
                        default:                           state_reg <= ST_OUT;
                    endcase
                end
                ST_CROSS:
                    state_reg <= ST_COMB;
                ST_COMB:
                    state_reg <= (item_reg.op == OP_NORM) ? ST_SQRT : ST_OUT;
                ST_SQRT:
                    if (sqrt_done)
                        state_reg <= div_start ? ST_DIV : ST_OUT;
                ST_DIV:
                    if (div_done[0])
                        state_reg <= ST_OUT;
                ST_OUT:
                    if (out_free)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // normalize with zero root: magsq products left in res_reg would be wrong, clear via START
    assign rsp.valid        = out_valid_reg;
    assign rsp.res_x        = out_x_reg;
    assign rsp.res_y        = out_y_reg;
    assign rsp.res_z        = out_z_reg;
    assign rsp.zero_divisor = out_z_flag_reg;

endmodule

// ===== dv/fpv3_checker.sv =====
`timescale 1ns / 1ps

module fpv3_checker (
    input  logic       clk,
    input  logic       rst_n,
    fpv3_req_if        req,
    fpv3_rsp_if        rsp,
    output int         fail_count,
    output int         pending
);
    import fpv3_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zdiv;
    } vec_word_t;

    vec_word_t expected_words[$];

    function automatic longint clamp_q(input longint v);
        if (v > longint'(SAT_MAX))
            return longint'(SAT_MAX);
        if (v < -longint'(SAT_MAX))
            return -longint'(SAT_MAX);
        return v;
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp_q(p >>> FRAC_BITS);
    endfunction

    function automatic longint q_div(input longint a, input longint b);
        if (b == 0)
            return longint'(SAT_MAX);
        return clamp_q((a * (64'sd1 <<< FRAC_BITS)) / b);
    endfunction

    function automatic longint wrap32(input longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return longint'(t);
    endfunction

    function automatic longint q_root(input longint a);
        longint unsigned n, root, bitv;
        if (a <= 0)
            return 0;
        n = longint'(a) << FRAC_BITS;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic longint len_sq(input longint a[3]);
        longint s;
        s = q_mul(a[0], a[0]);
        s = wrap32(s + q_mul(a[1], a[1]));
        return wrap32(s + q_mul(a[2], a[2]));
    endfunction

    function automatic vec_word_t vec_compute(input logic [3:0] cmd, input longint a[3],
                                              input longint b[3]);
        vec_word_t w;
        longint r[3];
        longint mag;
        logic zd;
        r = '{0, 0, 0};
        zd = 1'b0;
        case (cmd)
            CMD_ADD:
                for (int i = 0; i < 3; i++) r[i] = wrap32(a[i] + b[i]);
            CMD_SUB:
                for (int i = 0; i < 3; i++) r[i] = wrap32(a[i] - b[i]);
            CMD_MUL:
                for (int i = 0; i < 3; i++) r[i] = q_mul(a[i], b[i]);
            CMD_DIV:
                for (int i = 0; i < 3; i++)
                begin
                    if (b[i] == 0)
                        zd = 1'b1;
                    r[i] = q_div(a[i], b[i]);
                end
            CMD_MIN:
                for (int i = 0; i < 3; i++) r[i] = (a[i] < b[i]) ? a[i] : b[i];
            CMD_MAX:
                for (int i = 0; i < 3; i++) r[i] = (a[i] > b[i]) ? a[i] : b[i];
            CMD_DOT:
                r[0] = wrap32(wrap32(q_mul(a[0], b[0]) + q_mul(a[1], b[1]))
                              + q_mul(a[2], b[2]));
            CMD_CROSS:
            begin
                r[0] = wrap32(q_mul(a[1], b[2]) - q_mul(a[2], b[1]));
                r[1] = wrap32(q_mul(a[2], b[0]) - q_mul(a[0], b[2]));
                r[2] = wrap32(q_mul(a[0], b[1]) - q_mul(a[1], b[0]));
            end
            CMD_MAGSQ:
                r[0] = len_sq(a);
            CMD_NORM:
            begin
                mag = q_root(len_sq(a));
                if (mag != 0)
                    for (int i = 0; i < 3; i++) r[i] = q_div(a[i], mag);
            end
            CMD_SQRT:
                r[0] = q_root(a[0]);
            default: ;
        endcase
        w.x = r[0][31:0];
        w.y = r[1][31:0];
        w.z = r[2][31:0];
        w.zdiv = zd;
        return w;
    endfunction

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        vec_word_t e;
        longint a[3], b[3];
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                a = '{longint'(req.a_x), longint'(req.a_y), longint'(req.a_z)};
                b = '{longint'(req.b_x), longint'(req.b_y), longint'(req.b_z)};
                expected_words.push_back(vec_compute(req.command, a, b));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (rsp.res_x !== e.x || rsp.res_y !== e.y || rsp.res_z !== e.z
                        || rsp.zero_divisor !== e.zdiv)
                        fail_count <= fail_count + 1;
                    if (rsp.res_x !== e.x)
                        $error("res_x expected %h actual %h", e.x, rsp.res_x);
                    if (rsp.res_y !== e.y)
                        $error("res_y expected %h actual %h", e.y, rsp.res_y);
                    if (rsp.res_z !== e.z)
                        $error("res_z expected %h actual %h", e.z, rsp.res_z);
                    if (rsp.zero_divisor !== e.zdiv)
                        $error("zero_divisor expected %b actual %b", e.zdiv,
                               rsp.zero_divisor);
                end
            end
        end
    end
endmodule

// ===== dv/tb_fixed_point_vec3_alu.sv =====
`timescale 1ns / 1ps

module tb_fixed_point_vec3_alu;
    import fpv3_pkg::*;

    localparam int N_RANDOM = 1430;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   no_idle;
    bit   stim_done;

    fpv3_req_if req ();
    fpv3_rsp_if rsp ();

    fixed_point_vec3_alu u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    fpv3_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] lane_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(0);
            3: return 32'($signed($urandom_range(0, 2047)) - 1024);
            4: return 32'($signed($urandom_range(0, 65535)) - 32768);
            5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [3:0] cmd, input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] az, input logic [31:0] bx,
                             input logic [31:0] by, input logic [31:0] bz);
        while (!no_idle && $urandom_range(0, 99) < 29)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= cmd;
        req.a_x <= ax;
        req.a_y <= ay;
        req.a_z <= az;
        req.b_x <= bx;
        req.b_y <= by;
        req.b_z <= bz;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (no_idle)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 99) >= 29);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] cmd;
        idle_cycles = 0;
        no_idle = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.command = CMD_ADD;
        req.a_x = '0;
        req.a_y = '0;
        req.a_z = '0;
        req.b_x = '0;
        req.b_y = '0;
        req.b_z = '0;
        rsp.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100, 32'h1, 32'hFFFF_FFFF, 32'h200);
        send_word(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0);
        send_word(CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FF00, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h1);
        send_word(CMD_DIV, 32'h100, 32'hFFFF_FF00, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h1,
                  32'h7FFF_FFFF);
        send_word(CMD_DIV, 32'h8000_0000, 32'h300, 32'hFFFF_FD00, 32'hFFFF_FFFF, 32'h200,
                  32'h200);
        send_word(CMD_MIN, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5, 32'h8000_0000, 32'h0, 32'h5);
        send_word(CMD_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5, 32'h8000_0000, 32'h0, 32'h5);
        send_word(CMD_DOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_CROSS, 32'h100, 32'h0, 32'h0, 32'h0, 32'h100, 32'h0);
        send_word(CMD_MAGSQ, 32'h300, 32'h400, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_NORM, 32'h300, 32'h400, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_NORM, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1);
        send_word(CMD_NORM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_NORM, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_SQRT, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_SQRT, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_SQRT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(CMD_SQRT, 32'h400, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(4'd11, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
        send_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_idle = (i >= 500 && i < 700);
            if ($urandom_range(0, 19) == 0)
                cmd = 4'($urandom_range(11, 15));
            else
                cmd = 4'($urandom_range(0, 10));
            send_word(cmd, lane_value(), lane_value(), lane_value(), lane_value(),
                      lane_value(), lane_value());
        end
        req.valid <= 1'b0;
        no_idle = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
